>>> sv/assert_macros.svh
// Assertion macros shared by the setpoint editor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> sv/fpse_pkg.sv
// Types, constants and helper functions of the front panel setpoint editor.
`timescale 1ns / 1ps

package fpse_pkg;

    // Field widths.
    localparam int VOLT_W   = 10;
    localparam int CURR_W   = 10;
    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 8;
    localparam int LEVELS_W = 5;
    localparam int PLIM_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Repeat intervals and steps.
    localparam logic [TIME_W-1:0] VOLT_SLOW_MS = 32'd70;
    localparam logic [TIME_W-1:0] VOLT_FAST_MS = 32'd100;
    localparam logic [TIME_W-1:0] CURR_SLOW_MS = 32'd200;
    localparam logic [TIME_W-1:0] CURR_FAST_MS = 32'd50;
    localparam logic signed [12:0] VOLT_FAST_STEP = 13'sd10;
    localparam logic signed [12:0] VOLT_SLOW_STEP = 13'sd1;

    // Reset values of the registers and the setpoints.
    localparam logic [VOLT_W-1:0] VOLT_MIN_RST    = 10'd200;
    localparam logic [VOLT_W-1:0] VOLT_MAX_RST    = 10'd1000;
    localparam logic [CURR_W-1:0] CURR_MIN_RST    = 10'd10;
    localparam logic [CURR_W-1:0] CURR_MAX_RST    = 10'd150;
    localparam logic [PLIM_W-1:0] POWER_LIMIT_RST = 16'd50000;
    localparam logic [HOLD_W-1:0] FAST_AFTER_RST  = 8'd37;
    localparam logic [15:0]       LOCKOUT_RST     = 16'd5000;
    localparam logic [VOLT_W-1:0] VOLT_SET_RST    = 10'd200;
    localparam logic [CURR_W-1:0] CURR_SET_RST    = 10'd5;

    // Power clamp divider: one quotient bit per cycle.
    localparam int DIV_STEPS = PLIM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLT_MIN    = 3'd0,
        CFG_VOLT_MAX    = 3'd1,
        CFG_CURR_MIN    = 3'd2,
        CFG_CURR_MAX    = 3'd3,
        CFG_POWER_LIMIT = 3'd4,
        CFG_FAST_AFTER  = 3'd5,
        CFG_LOCKOUT     = 3'd6
    } cfg_index_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_FINISH,
        ST_PUBLISH
    } ctrl_state_t;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [VOLT_W-1:0] volt_min;
        logic [VOLT_W-1:0] volt_max;
        logic [CURR_W-1:0] curr_min;
        logic [CURR_W-1:0] curr_max;
        logic [PLIM_W-1:0] power_limit;
        logic [HOLD_W-1:0] fast_after;
        logic [15:0]       toggle_lockout_ms;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic calc;
        logic div_step;
        logic finish;
        logic publish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early;
        logic div_last;
    } dp_status_t;

    // One result beat.
    typedef struct packed {
        logic              editing;
        logic              row;
        logic              page;
        logic              power_on;
        logic [CURR_W-1:0] current_setpoint;
        logic [VOLT_W-1:0] voltage_setpoint;
    } result_t;

    // Division by ten through a reciprocal multiply; exact for values below 1100.
    function automatic logic [6:0] div10(input logic [10:0] x);
        logic [24:0] prod;
        begin
            prod = {14'd0, x} * 25'd6554;
            div10 = prod[22:16];
        end
    endfunction

    // Clamp to [lo, hi]; the upper bound is applied first, so lo wins if lo > hi.
    function automatic logic [9:0] clamp10(input logic signed [12:0] v,
                                           input logic [9:0] lo,
                                           input logic [9:0] hi);
        logic signed [12:0] t;
        begin
            t = (v > $signed({3'b000, hi})) ? $signed({3'b000, hi}) : v;
            t = (t < $signed({3'b000, lo})) ? $signed({3'b000, lo}) : t;
            clamp10 = t[9:0];
        end
    endfunction

endpackage

>>> sv/fpse_ctrl.sv
// Controller state machine of the setpoint editor: sequences one poll at a time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpse_ctrl
    import fpse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_free,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = status.early ? ST_PUBLISH : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An accepted beat is always processed in the following cycle.
    `ASSERT_NEXT(a_accept_to_calc, (in_valid && in_ready), (state_reg == ST_CALC),
                 "accepted beat did not start processing")
    // A result is only loaded when the output register can take it.
    `ASSERT_SAME(a_publish_free, cmd.publish, out_free,
                 "result published over a pending beat")
    // No poll work is commanded while the input side is open.
    `ASSERT_SAME(a_ready_quiet, in_ready, (!cmd.calc && !cmd.div_step && !cmd.finish),
                 "datapath busy while ready")

endmodule

>>> sv/fpse_dp.sv
// Datapath of the setpoint editor: panel state, step logic and the power clamp divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpse_dp
    import fpse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  cfg_t                cfg,
    input  logic [LEVELS_W-1:0] levels_in,
    input  logic [TIME_W-1:0]   now_in,
    output dp_status_t          status,
    output result_t             result
);

    // Latched poll.
    logic [LEVELS_W-1:0] levels_reg, levels_next;
    logic [TIME_W-1:0]   now_reg, now_next;

    // Panel state.
    logic [LEVELS_W-1:0] prev_levels_reg, prev_levels_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic [TIME_W-1:0]   vut_reg, vut_next;
    logic [TIME_W-1:0]   vdt_reg, vdt_next;
    logic [TIME_W-1:0]   cut_reg, cut_next;
    logic [TIME_W-1:0]   cdt_reg, cdt_next;
    logic [TIME_W-1:0]   toggle_time_reg, toggle_time_next;
    logic                page_reg, page_next;
    logic                row_reg, row_next;
    logic                edit_reg, edit_next;
    logic                power_reg, power_next;
    logic [VOLT_W-1:0]   volt_reg, volt_next;
    logic [CURR_W-1:0]   curr_reg, curr_next;

    // Divider.
    logic [VOLT_W-1:0]    div_rem_reg, div_rem_next;
    logic [PLIM_W-1:0]    div_quot_reg, div_quot_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // Poll decode and step terms.
    logic                bl, br, bm, bt, bb;
    logic                editing, idle_poll;
    logic [HOLD_W-1:0]   hold_a, hold_b;
    logic [1:0]          sel;
    logic                toggle_br, edit_br, lock_ok;
    logic                fast, at_fast, down, up;
    logic [10:0]         tens_src, v_round, v_base;
    logic [6:0]          tens_q;
    logic [TIME_W-1:0]   vut_base, vdt_base, iv, ic;
    logic                v_dn_ok, v_up_ok, c_dn_ok, c_up_ok;
    logic signed [12:0]  sv, v_step, c_step;
    logic [10:0]         div_trial;
    logic                div_ge;

    assign bl = levels_reg[0];
    assign br = levels_reg[1];
    assign bm = levels_reg[2];
    assign bt = levels_reg[3];
    assign bb = levels_reg[4];

    assign editing   = edit_reg & page_reg;
    assign idle_poll = bt & bb & (!editing | (bl & br));

    assign status.early    = idle_poll && (levels_reg[2:0] == prev_levels_reg[2:0]);
    assign status.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    assign result.voltage_setpoint = volt_reg;
    assign result.current_setpoint = curr_reg;
    assign result.power_on         = power_reg;
    assign result.page             = page_reg;
    assign result.row              = row_reg;
    assign result.editing          = edit_reg;

    // Step terms of one poll.
    always_comb
    begin
        hold_a = idle_poll ? '0 : ((hold_reg == '1) ? hold_reg : hold_reg + 8'd1);
        sel    = {1'b0, edit_reg} + {1'b0, !bm};
        hold_b = !bm ? '0 : hold_a;

        toggle_br = (sel == 2'd1) && !page_reg;
        edit_br   = (sel == 2'd1) && page_reg;
        lock_ok   = (toggle_time_reg == '0) ||
                    ((now_reg - toggle_time_reg) >= {16'd0, cfg.toggle_lockout_ms});

        fast    = hold_b > cfg.fast_after;
        at_fast = ({1'b0, hold_b} == ({1'b0, cfg.fast_after} + 9'd1));
        down    = !bb || !bl;
        up      = !bt || !br;

        // Round the voltage to a multiple of ten on the first fast step.
        tens_src = down ? {1'b0, volt_reg} : ({1'b0, volt_reg} + 11'd9);
        tens_q   = div10(tens_src);
        v_round  = {1'b0, tens_q, 3'b000} + {3'b000, tens_q, 1'b0};
        v_base   = (at_fast && (down || up)) ? v_round : {1'b0, volt_reg};
        vut_base = at_fast ? now_reg : (idle_poll ? '0 : vut_reg);
        vdt_base = at_fast ? now_reg : (idle_poll ? '0 : vdt_reg);

        // Voltage repeat.
        iv      = fast ? VOLT_FAST_MS : VOLT_SLOW_MS;
        sv      = fast ? VOLT_FAST_STEP : VOLT_SLOW_STEP;
        v_dn_ok = down && ((now_reg - vdt_base) >= iv);
        v_up_ok = up && ((now_reg - vut_base) >= iv);
        v_step  = $signed({2'b00, v_base}) - (v_dn_ok ? sv : 13'sd0)
                  + (v_up_ok ? sv : 13'sd0);

        // Current repeat.
        ic      = fast ? CURR_FAST_MS : CURR_SLOW_MS;
        c_dn_ok = down && ((now_reg - (idle_poll ? '0 : cdt_reg)) >= ic);
        c_up_ok = up && ((now_reg - (idle_poll ? '0 : cut_reg)) >= ic);
        c_step  = $signed({3'b000, curr_reg}) - (c_dn_ok ? 13'sd1 : 13'sd0)
                  + (c_up_ok ? 13'sd1 : 13'sd0);

        // One restoring divide step.
        div_trial = {div_rem_reg, div_quot_reg[PLIM_W-1]};
        div_ge    = div_trial >= {1'b0, volt_reg};
    end

    // Next-state selection by command.
    always_comb
    begin
        levels_next      = levels_reg;
        now_next         = now_reg;
        prev_levels_next = prev_levels_reg;
        hold_next        = hold_reg;
        vut_next         = vut_reg;
        vdt_next         = vdt_reg;
        cut_next         = cut_reg;
        cdt_next         = cdt_reg;
        toggle_time_next = toggle_time_reg;
        page_next        = page_reg;
        row_next         = row_reg;
        edit_next        = edit_reg;
        power_next       = power_reg;
        volt_next        = volt_reg;
        curr_next        = curr_reg;
        div_rem_next     = div_rem_reg;
        div_quot_next    = div_quot_reg;
        div_cnt_next     = div_cnt_reg;

        if (cmd.load_in)
        begin
            levels_next = levels_in;
            now_next    = now_in;
        end

        if (cmd.calc)
        begin
            prev_levels_next = levels_reg;
            if (status.early)
            begin
                // Quiet poll: clear the repeat state and keep everything else but the recorded levels.
                hold_next = '0;
                vut_next  = '0;
                vdt_next  = '0;
                cut_next  = '0;
                cdt_next  = '0;
            end
            else
            begin
                hold_next = hold_b;
                vut_next  = idle_poll ? '0 : vut_reg;
                vdt_next  = idle_poll ? '0 : vdt_reg;
                cut_next  = idle_poll ? '0 : cut_reg;
                cdt_next  = idle_poll ? '0 : cdt_reg;

                // Select on the status page toggles power outside the lockout.
                if (toggle_br && lock_ok)
                begin
                    power_next       = !power_reg;
                    toggle_time_next = (now_reg != '0) ? now_reg : 32'd1;
                end

                if (edit_br)
                begin
                    if (!row_reg)
                    begin
                        vut_next = v_up_ok ? now_reg : vut_base;
                        vdt_next = v_dn_ok ? now_reg : vdt_base;
                    end
                    else
                    begin
                        if (c_up_ok)
                        begin
                            cut_next = now_reg;
                        end
                        if (c_dn_ok)
                        begin
                            cdt_next = now_reg;
                        end
                    end
                end
                else
                begin
                    // Navigation: edges of top and bottom move the row, levels move the page.
                    row_next  = row_reg ^ (!bb && prev_levels_reg[4])
                                        ^ (!bt && prev_levels_reg[3]);
                    page_next = page_reg ^ !br ^ !bl;
                end

                edit_next = edit_br;
                volt_next = clamp10((edit_br && !row_reg) ? v_step
                                                          : $signed({3'b000, volt_reg}),
                                    cfg.volt_min, cfg.volt_max);
                curr_next = clamp10((edit_br && row_reg) ? c_step
                                                         : $signed({3'b000, curr_reg}),
                                    cfg.curr_min, cfg.curr_max);

                // Start the power limit divide.
                div_rem_next  = '0;
                div_quot_next = cfg.power_limit;
                div_cnt_next  = '0;
            end
        end

        if (cmd.div_step)
        begin
            div_rem_next  = div_ge ? VOLT_W'(div_trial - {1'b0, volt_reg})
                                   : div_trial[VOLT_W-1:0];
            div_quot_next = {div_quot_reg[PLIM_W-2:0], div_ge};
            div_cnt_next  = div_cnt_reg + DIV_CNT_W'(1);
        end

        // Clamp the current to power_limit / voltage unless the voltage is zero.
        if (cmd.finish)
        begin
            if ((volt_reg != '0) && ({6'd0, curr_reg} > div_quot_reg))
            begin
                curr_next = div_quot_reg[CURR_W-1:0];
            end
        end
    end

    // Panel state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_levels_reg <= '0;
            hold_reg        <= '0;
            vut_reg         <= '0;
            vdt_reg         <= '0;
            cut_reg         <= '0;
            cdt_reg         <= '0;
            toggle_time_reg <= '0;
            page_reg        <= 1'b1;
            row_reg         <= 1'b0;
            edit_reg        <= 1'b0;
            power_reg       <= 1'b0;
            volt_reg        <= VOLT_SET_RST;
            curr_reg        <= CURR_SET_RST;
        end
        else
        begin
            prev_levels_reg <= prev_levels_next;
            hold_reg        <= hold_next;
            vut_reg         <= vut_next;
            vdt_reg         <= vdt_next;
            cut_reg         <= cut_next;
            cdt_reg         <= cdt_next;
            toggle_time_reg <= toggle_time_next;
            page_reg        <= page_next;
            row_reg         <= row_next;
            edit_reg        <= edit_next;
            power_reg       <= power_next;
            volt_reg        <= volt_next;
            curr_reg        <= curr_next;
        end
    end

    // Poll latch and divider registers.
    always_ff @(posedge clk)
    begin
        levels_reg   <= levels_next;
        now_reg      <= now_next;
        div_rem_reg  <= div_rem_next;
        div_quot_reg <= div_quot_next;
        div_cnt_reg  <= div_cnt_next;
    end

    // A quiet poll leaves both setpoints untouched.
    `ASSERT_NEXT(a_early_keeps_setpoints, (cmd.calc && status.early),
                 ($stable(volt_reg) && $stable(curr_reg)),
                 "quiet poll changed a setpoint")
    // With ordered limits the voltage setpoint lands inside them.
    `ASSERT_NEXT(a_volt_in_range,
                 (cmd.calc && !status.early && (cfg.volt_min <= cfg.volt_max)),
                 ((volt_reg >= $past(cfg.volt_min)) && (volt_reg <= $past(cfg.volt_max))),
                 "voltage setpoint outside its limits")
    // After the divide the current never exceeds the power quotient.
    `ASSERT_NEXT(a_power_clamp, (cmd.finish && (volt_reg != '0)),
                 (({6'd0, curr_reg}) <= $past(div_quot_reg)),
                 "current setpoint above power limit")

endmodule

>>> sv/front_panel_setpoint_editor_unit.sv
// Top level of the front panel setpoint editor: ports, registers and output beat.
`timescale 1ns / 1ps

// One poll of the five button levels and the millisecond time is taken at a
// time and yields one result beat with the setpoints, power request, page, row
// and edit flag. A poll that changes nothing goes from its update straight to
// the output load, and the next poll is accepted only after that load. Any
// other poll passes through the update, the bit-serial divider that computes
// power_limit / voltage for the current clamp, the clamp and the output load,
// and the next poll is accepted only after that load. The result beat waits in
// an output register, so a slow consumer only stalls the block when a second
// result is ready. There is no clearing pass after reset. Configuration writes
// take effect at once and should be made while no poll is in flight.
module front_panel_setpoint_editor_unit
    import fpse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // btn_left, btn_right, btn_middle, btn_up, btn_down, now_ms[31:0], 3 zero bits
    input  logic [39:0]          s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // voltage_setpoint[9:0], current_setpoint[9:0], power_on, page, row, editing
    output logic [23:0]          m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t       cfg_reg, cfg_next;
    logic       m_tvalid_reg, m_tvalid_next;
    result_t    out_data_reg, out_data_next;
    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    result;
    logic       out_free;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_VOLT_MIN:    cfg_next.volt_min          = cfg_wdata[VOLT_W-1:0];
                CFG_VOLT_MAX:    cfg_next.volt_max          = cfg_wdata[VOLT_W-1:0];
                CFG_CURR_MIN:    cfg_next.curr_min          = cfg_wdata[CURR_W-1:0];
                CFG_CURR_MAX:    cfg_next.curr_max          = cfg_wdata[CURR_W-1:0];
                CFG_POWER_LIMIT: cfg_next.power_limit       = cfg_wdata[PLIM_W-1:0];
                CFG_FAST_AFTER:  cfg_next.fast_after        = cfg_wdata[HOLD_W-1:0];
                CFG_LOCKOUT:     cfg_next.toggle_lockout_ms = cfg_wdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volt_min          <= VOLT_MIN_RST;
            cfg_reg.volt_max          <= VOLT_MAX_RST;
            cfg_reg.curr_min          <= CURR_MIN_RST;
            cfg_reg.curr_max          <= CURR_MAX_RST;
            cfg_reg.power_limit       <= POWER_LIMIT_RST;
            cfg_reg.fast_after        <= FAST_AFTER_RST;
            cfg_reg.toggle_lockout_ms <= LOCKOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Output beat register.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        out_data_next = out_data_reg;
        m_tvalid_next = m_tvalid_reg;
        if (cmd.publish)
        begin
            out_data_next = result;
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    // Controller.
    fpse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    fpse_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .levels_in (s_tdata[LEVELS_W-1:0]),
        .now_in    (s_tdata[LEVELS_W+TIME_W-1:LEVELS_W]),
        .status    (status),
        .result    (result)
    );

endmodule
